FILE: rtl/rppk_pkg.sv
// Shared types and constants of the raw pixel bit packer.
package rppk_pkg;

  localparam int WORD_W  = 16;

  localparam logic [1:0] DEPTH_10 = 2'd0;
  localparam logic [1:0] DEPTH_12 = 2'd1;
  localparam logic [1:0] DEPTH_14 = 2'd2;
  localparam logic [1:0] DEPTH_MODE_RESET = DEPTH_14;

  localparam logic [15:0] MASK_10 = 16'h03FF;
  localparam logic [15:0] MASK_12 = 16'h0FFF;
  localparam logic [15:0] MASK_14 = 16'h3FFF;

  // Register index, decoded from the word address.
  localparam logic REG_DEPTH_MODE = 1'b0;

  // Words produced by one pixel: one or two.
  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic              last0;
    logic [WORD_W-1:0] word1;
    logic              last1;
    logic              two;
  } pack_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

FILE: rtl/rppk_front.sv
// Front end: accepts pixels, updates the bit accumulator and forms packed words.
module rppk_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                depth_mode,
  input  logic [15:0]               pixel,
  input  logic                      last,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  rppk_pkg::queue_status_t   queue_status,
  output logic                      push,
  output rppk_pkg::pack_entry_t     entry
);
  import rppk_pkg::*;

  logic [14:0] pending_bits;
  logic [3:0]  pending_count;
  logic [14:0] pending_bits_next;
  logic [3:0]  pending_count_next;

  logic        accept;
  logic [3:0]  d;
  logic [15:0] mask;
  logic [28:0] acc;
  logic [4:0]  total;
  logic        full;
  logic [3:0]  left;
  logic [14:0] keep_mask;
  logic [14:0] rem;
  logic [15:0] full_word;
  logic [15:0] pad_word;
  logic        has_pad;

  assign pixel_stall = queue_status.full;
  assign accept      = pixel_valid && !pixel_stall;

  always_comb begin
    case (depth_mode)
      DEPTH_10: begin
        d    = 4'd10;
        mask = MASK_10;
      end
      DEPTH_12: begin
        d    = 4'd12;
        mask = MASK_12;
      end
      default: begin
        d    = 4'd14;
        mask = MASK_14;
      end
    endcase
  end

  always_comb begin
    acc       = ({14'd0, pending_bits} << d) | {13'd0, pixel & mask};
    total     = {1'b0, pending_count} + {1'b0, d};
    full      = total[4];
    left      = total[3:0];
    full_word = 16'(acc >> left);
    keep_mask = (15'd1 << left) - 15'd1;
    rem       = acc[14:0] & keep_mask;
    pad_word  = {rem, 1'b0} << (4'd15 - left);
    has_pad   = last && (left != 4'd0);

    entry.word0 = full ? full_word : pad_word;
    entry.last0 = full ? (last && (left == 4'd0)) : 1'b1;
    entry.word1 = pad_word;
    entry.last1 = 1'b1;
    entry.two   = full && has_pad;

    push = accept && (full || has_pad);

    if (last) begin
      pending_bits_next  = 15'd0;
      pending_count_next = 4'd0;
    end else begin
      pending_bits_next  = rem;
      pending_count_next = left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= 15'd0;
      pending_count <= 4'd0;
    end else if (accept) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (pending_count == 4'd0 && pending_bits == 15'd0))
    else $error("accumulator not cleared after last pixel");

endmodule

FILE: rtl/rppk_queue.sv
// Short queue of packed-word groups between front and back end.
module rppk_queue #(
  parameter int DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  rppk_pkg::pack_entry_t     push_entry,
  input  logic                      pop,
  output rppk_pkg::pack_entry_t     head,
  output rppk_pkg::queue_status_t   status
);
  import rppk_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pack_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full      = (count == FULL_CNT);
  assign status.not_empty = (count != '0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head             = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !status.not_empty))
    else $error("pop from empty queue");

endmodule

FILE: rtl/rppk_back.sv
// Back end: drains word groups from the queue into the output register.
module rppk_back (
  input  logic                      clk,
  input  logic                      rst,
  input  rppk_pkg::pack_entry_t     head,
  input  rppk_pkg::queue_status_t   queue_status,
  output logic                      pop,
  output logic [15:0]               packed_word,
  output logic                      last_word,
  output logic                      word_valid,
  input  logic                      word_stall
);
  import rppk_pkg::*;

  logic              sec_valid;
  logic [WORD_W-1:0] sec_word;
  logic              sec_last;
  logic              load;

  assign load = !word_valid || !word_stall;
  assign pop  = load && !sec_valid && queue_status.not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      sec_valid  <= 1'b0;
    end else if (load) begin
      if (sec_valid) begin
        word_valid <= 1'b1;
        sec_valid  <= 1'b0;
      end else begin
        word_valid <= queue_status.not_empty;
        sec_valid  <= queue_status.not_empty && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid) begin
        packed_word <= sec_word;
        last_word   <= sec_last;
      end else begin
        packed_word <= head.word0;
        last_word   <= head.last0;
        sec_word    <= head.word1;
        sec_last    <= head.last1;
      end
    end
  end

  a_second_behind_first: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> (word_valid && !last_word))
    else $error("second word pending without a first word ahead of it");

endmodule

FILE: rtl/raw_pixel_bit_packer_unit.sv
// Raw pixel bit packer: top level with configuration port.
// Packs the low 10, 12 or 14 bits of each pixel (depth_mode 0/1/2, 3 acts as 14; reset 14)
// MSB first into 16-bit words; the first pixel's top bit lands in bit 15 of the first word.
// A pixel marked last flushes leftover bits as a zero-padded word, and the final word of
// the frame carries last_word. One pixel is taken per cycle while pixel_stall is low; words
// go via the queue to the output register, one per cycle unless word_stall holds it, so a
// last pixel with two words needs the output for both; a FIFO_DEPTH-entry queue between
// accumulator and output register absorbs that, and pixel_stall rises only when it is full.
// depth_mode sits at byte address 0 and should be written only between frames.
module raw_pixel_bit_packer_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [15:0] pixel,
  input  logic        last,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  output logic [15:0] packed_word,
  output logic        last_word,
  output logic        word_valid,
  input  logic        word_stall
);
  import rppk_pkg::*;

  logic          [1:0] depth_mode;
  logic                cfg_write;
  logic                push;
  logic                pop;
  pack_entry_t         push_entry;
  pack_entry_t         head;
  queue_status_t       queue_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DEPTH_MODE);
  assign prdata    = (paddr[2] == REG_DEPTH_MODE) ? {30'd0, depth_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= DEPTH_MODE_RESET;
    end else if (cfg_write) begin
      depth_mode <= pwdata[1:0];
    end
  end

  rppk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .depth_mode   (depth_mode),
    .pixel        (pixel),
    .last         (last),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .queue_status (queue_status),
    .push         (push),
    .entry        (push_entry)
  );

  rppk_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (queue_status)
  );

  rppk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .queue_status (queue_status),
    .pop          (pop),
    .packed_word  (packed_word),
    .last_word    (last_word),
    .word_valid   (word_valid),
    .word_stall   (word_stall)
  );

endmodule

FILE: bench/raw_pixel_bit_packer_unit_tb.sv
// Testbench for the raw pixel bit packer: directed table, random frames, word-by-word check.
`timescale 1ns / 1ps

module raw_pixel_bit_packer_unit_tb;
  import rppk_pkg::*;

  localparam logic [1:0] DEPTH_UNUSED = 2'd3;
  localparam logic [2:0] DEPTH_ADDR = {REG_DEPTH_MODE, 2'b00};
  localparam int DRAIN_CYCLES = 12;
  localparam int N_ROWS = 20;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    logic [15:0] word;
    logic        last_flag;
  } word_exp_t;

  // typed_n < 0: expected words come from the packer model
  typedef struct {
    logic [1:0]  depth;
    logic [15:0] pix;
    logic        lst;
    int          typed_n;
    word_exp_t   w0;
    word_exp_t   w1;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [15:0] pixel = '0;
  logic        last = 1'b0;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  logic [15:0] packed_word;
  logic        last_word;
  logic        word_valid;
  logic        word_stall = 1'b0;

  raw_pixel_bit_packer_unit u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixel(pixel), .last(last), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .packed_word(packed_word), .last_word(last_word), .word_valid(word_valid),
    .word_stall(word_stall)
  );

  logic [1:0]  depth_cfg;
  logic [14:0] pend_bits;
  logic [3:0]  pend_cnt;
  word_exp_t   exp_words[$];
  bit          gaps_on = 1'b1;
  int          errors = 0;
  int          pixels_sent = 0;
  int          words_seen = 0;
  int          frames_sent = 0;
  dir_row_t    dir_rows [N_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("raw_pixel_bit_packer_unit_tb NOT OK");
    $finish;
  end

  task automatic pack_pixel(input logic [15:0] p, input logic l, output int n,
                            output word_exp_t r0, output word_exp_t r1);
    int unsigned d;
    int unsigned total;
    int unsigned rest;
    logic [15:0] mask;
    logic [28:0] acc;
    word_exp_t   r [2];
    case (depth_cfg)
      DEPTH_10: begin d = 10; mask = MASK_10; end
      DEPTH_12: begin d = 12; mask = MASK_12; end
      default: begin d = 14; mask = MASK_14; end
    endcase
    n = 0;
    r[0] = '0;
    r[1] = '0;
    acc = (29'(pend_bits) << d) | 29'(p & mask);
    total = pend_cnt + d;
    if (total >= 16) begin
      rest = total - 16;
      r[n] = '{word: 16'(acc >> rest), last_flag: l && (rest == 0)};
      n++;
      total = rest;
      acc &= (29'(1) << total) - 29'(1);
    end
    if (l) begin
      if (total > 0) begin
        r[n] = '{word: 16'(acc << (16 - total)), last_flag: 1'b1};
        n++;
      end
      pend_bits = '0;
      pend_cnt = '0;
    end else begin
      pend_bits = acc[14:0];
      pend_cnt = total[3:0];
    end
    r0 = r[0];
    r1 = r[1];
  endtask

  task automatic send_pixel(input logic [15:0] p, input logic l, input int typed_n,
                            input word_exp_t t0, input word_exp_t t1);
    int n;
    word_exp_t r0;
    word_exp_t r1;
    if (gaps_on) begin
      while ($urandom_range(99) < 32) begin
        pixel_valid <= 1'b0;
        @(posedge clk);
      end
    end
    pixel <= p;
    last <= l;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    pack_pixel(p, l, n, r0, r1);
    if (typed_n >= 0) begin
      n = typed_n;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) exp_words.push_back(r0);
    if (n > 1) exp_words.push_back(r1);
    pixels_sent++;
    if (l) frames_sent++;
  endtask

  // stop the pixel stream and let every word come out
  task automatic drain;
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (exp_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(input logic [1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DEPTH_ADDR;
    pwdata <= 32'(d);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    depth_cfg = d;
  endtask

  always @(posedge clk) begin
    word_exp_t e;
    if (!rst && word_valid && !word_stall) begin
      if (exp_words.size() == 0) begin
        $error("unexpected item: packed_word %h last_word %b", packed_word, last_word);
        errors++;
      end else begin
        e = exp_words.pop_front();
        if (packed_word !== e.word) begin
          $error("packed_word: expected %h, actual %h", e.word, packed_word);
          errors++;
        end
        if (last_word !== e.last_flag) begin
          $error("last_word: expected %b, actual %b", e.last_flag, last_word);
          errors++;
        end
        words_seen++;
      end
    end
    word_stall <= gaps_on && ($urandom_range(99) < 32);
  end

  initial begin
    int len;
    int sent;
    logic [15:0] p;
    logic [1:0] d;
    depth_cfg = DEPTH_MODE_RESET;
    pend_bits = '0;
    pend_cnt = '0;

    dir_rows[0]  = '{DEPTH_14, 16'hFFFF, 1'b1, 1, '{16'hFFFC, 1'b1}, '0};
    dir_rows[1]  = '{DEPTH_14, 16'h0000, 1'b1, 1, '{16'h0000, 1'b1}, '0};
    dir_rows[2]  = '{DEPTH_14, 16'h3FFF, 1'b0, -1, '0, '0};
    dir_rows[3]  = '{DEPTH_14, 16'hC000, 1'b1, 2, '{16'hFFFC, 1'b0}, '{16'h0000, 1'b1}};
    dir_rows[4]  = '{DEPTH_10, 16'hFFFF, 1'b1, 1, '{16'hFFC0, 1'b1}, '0};
    dir_rows[5]  = '{DEPTH_10, 16'h0000, 1'b1, 1, '{16'h0000, 1'b1}, '0};
    dir_rows[6]  = '{DEPTH_12, 16'hFFFF, 1'b1, 1, '{16'hFFF0, 1'b1}, '0};
    // four 12-bit pixels fill three words exactly
    dir_rows[7]  = '{DEPTH_12, 16'hAAAA, 1'b0, -1, '0, '0};
    dir_rows[8]  = '{DEPTH_12, 16'h5555, 1'b0, -1, '0, '0};
    dir_rows[9]  = '{DEPTH_12, 16'h1234, 1'b0, -1, '0, '0};
    dir_rows[10] = '{DEPTH_12, 16'hFEDC, 1'b1, -1, '0, '0};
    dir_rows[11] = '{DEPTH_UNUSED, 16'hFFFF, 1'b1, 1, '{16'hFFFC, 1'b1}, '0};
    dir_rows[12] = '{DEPTH_UNUSED, 16'h8001, 1'b0, -1, '0, '0};
    dir_rows[13] = '{DEPTH_UNUSED, 16'h7FFE, 1'b1, -1, '0, '0};
    // depth switched with bits still pending
    dir_rows[14] = '{DEPTH_10, 16'h03FF, 1'b0, -1, '0, '0};
    dir_rows[15] = '{DEPTH_14, 16'h2AAA, 1'b0, -1, '0, '0};
    dir_rows[16] = '{DEPTH_12, 16'h0F0F, 1'b1, -1, '0, '0};
    dir_rows[17] = '{DEPTH_10, 16'hFC00, 1'b0, -1, '0, '0};
    dir_rows[18] = '{DEPTH_10, 16'h5A5A, 1'b0, -1, '0, '0};
    dir_rows[19] = '{DEPTH_10, 16'hA5A5, 1'b1, -1, '0, '0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].depth != depth_cfg) begin
        drain();
        write_depth(dir_rows[i].depth);
      end
      send_pixel(dir_rows[i].pix, dir_rows[i].lst, dir_rows[i].typed_n,
                 dir_rows[i].w0, dir_rows[i].w1);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: d = DEPTH_10;
        1: d = DEPTH_12;
        2: d = DEPTH_14;
        3: d = DEPTH_UNUSED;
        default: d = 2'($urandom_range(3));
      endcase
      write_depth(d);
      gaps_on = (ph != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 20);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(9))
            0: p = 16'h0000;
            1: p = 16'hFFFF;
            default: p = 16'($urandom);
          endcase
          send_pixel(p, k == len - 1, -1, '0, '0);
        end
        sent += len;
      end
    end

    drain();
    gaps_on = 1'b1;
    $display("covered %0d pixels in %0d frames, %0d packed words checked",
             pixels_sent, frames_sent, words_seen);
    $display("depth modes 10, 12, 14 and the unused code, with and without idle cycles");
    if (errors == 0 && exp_words.size() == 0) begin
      $display("raw_pixel_bit_packer_unit_tb OK");
    end else begin
      $display("raw_pixel_bit_packer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
